>>> rtl/core/rgta_pkg.sv
// ----------------------------------------------------------------------------
// rgta_pkg
// Shared types, constants and helpers of the RDS group text assembler.
// ----------------------------------------------------------------------------
package rgta_pkg;

   localparam int TEXT_LEN  = 64;
   localparam int NAME_LEN  = 8;
   localparam int ROW_BYTES = 4;
   localparam int ROWS      = TEXT_LEN / ROW_BYTES;
   localparam int ROW_W     = $clog2(ROWS);

   // commands
   localparam logic [1:0] CMD_GROUP = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // group types handled
   localparam logic [3:0] GROUP_PS = 4'd0;
   localparam logic [3:0] GROUP_RT = 4'd2;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] PRINT_LO   = 8'd32;
   localparam logic [7:0] PRINT_HI   = 8'd126;

   localparam logic [4:0] MIN_SEG_RESET = 5'd4;

   typedef logic [ROW_BYTES-1:0][7:0] row_type;

   typedef struct packed {
      logic    version_b;
      logic    half;
      row_type chars;
   } merge_req_type;

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] row;
      row_type          data;
   } ram_wr_type;

   function automatic logic printable(input logic [7:0] c);
      return (c >= PRINT_LO) && (c <= PRINT_HI);
   endfunction

   function automatic logic [2:0] nibble_count(input logic [3:0] n);
      return {2'b00, n[0]} + {2'b00, n[1]} + {2'b00, n[2]} + {2'b00, n[3]};
   endfunction

   function automatic logic [4:0] popcount16(input logic [15:0] v);
      return {2'b00, nibble_count(v[3:0])}  + {2'b00, nibble_count(v[7:4])}
           + {2'b00, nibble_count(v[11:8])} + {2'b00, nibble_count(v[15:12])};
   endfunction

   // text contents of a row after reset or wipe
   function automatic row_type reset_row(input logic [ROW_W-1:0] row);
      row_type r;
      r = {ROW_BYTES{CHAR_SPACE}};
      if (row == '0) begin
         r[0] = CHAR_NUL;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/rgta_text_ram.sv
// ----------------------------------------------------------------------------
// rgta_text_ram
// Radiotext row memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rgta_text_ram (
   input  logic                      clock,
   input  rgta_pkg::ram_wr_type      wr,
   input  logic                      rd_en,
   input  logic [rgta_pkg::ROW_W-1:0] rd_row,
   output rgta_pkg::row_type         rd_data
);

   rgta_pkg::row_type row_mem_ff [rgta_pkg::ROWS];
   rgta_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         row_mem_ff[wr.row] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= row_mem_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/rgta_row_merge.sv
// ----------------------------------------------------------------------------
// rgta_row_merge
// Merges the characters of one group into a radiotext row.
// ----------------------------------------------------------------------------
module rgta_row_merge (
   input  rgta_pkg::row_type       old_row,
   input  rgta_pkg::merge_req_type req,
   output rgta_pkg::row_type       new_row,
   output logic                    cr_seen
);

   // chars go in order; any char but the first is dropped after a NUL entry
   always_comb begin
      rgta_pkg::row_type cur;
      logic [1:0]        start;
      logic [1:0]        pos;
      logic              cr;
      cur   = old_row;
      cr    = 1'b0;
      pos   = 2'd0;
      start = req.version_b ? {req.half, 1'b0} : 2'd0;
      for (int k = 0; k < rgta_pkg::ROW_BYTES; k++) begin
         if (!req.version_b || k < 2) begin
            pos = start + 2'(k);
            if (k == 0 || cur[pos - 2'd1] != rgta_pkg::CHAR_NUL) begin
               if (req.chars[k] == rgta_pkg::CHAR_CR) begin
                  cur[pos] = rgta_pkg::CHAR_NUL;
                  cr       = 1'b1;
               end else if (rgta_pkg::printable(req.chars[k])) begin
                  cur[pos] = req.chars[k];
               end else begin
                  cur[pos] = rgta_pkg::CHAR_SPACE;
               end
            end
         end
      end
      new_row = cur;
      cr_seen = cr;
   end

endmodule

>>> rtl/core/rds_group_text_assembler.sv
// ----------------------------------------------------------------------------
// rds_group_text_assembler
// Builds station name and radiotext from decoded RDS groups; serves reads.
// ----------------------------------------------------------------------------
// Pipeline: the stage 1 register holds each transfer until commit, when the
//   merge result loads the output register; the response transfer follows.
// Throughput: one item per cycle unless the response stalls, set by the row
//   read at accept and the stage 1 merge and text RAM write-back (forwarding).
// Reset (synchronous): clears control, flags and the per-row valid bits; an
//   invalid row reads as its reset text, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module rds_group_text_assembler (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_min_ready_segments,
   // request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic        req_group_valid,
   input  logic [15:0] req_block_b,
   input  logic [15:0] req_block_c,
   input  logic [15:0] req_block_d,
   input  logic [6:0]  req_text_index,
   // response
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_group_taken,
   output logic [3:0]  rsp_group_kind,
   output logic [4:0]  rsp_program_type,
   output logic        rsp_traffic_program,
   output logic        rsp_text_ready,
   output logic [15:0] rsp_segments_seen,
   output logic        rsp_text_cleared,
   output logic [7:0]  rsp_char_out
);

   localparam int RW = rgta_pkg::ROW_W;
   localparam int NL = rgta_pkg::NAME_LEN;

   // ---- configuration register -------------------------------------------
   logic [4:0] min_seg_ff, min_seg_in;

   assign csr_ready = 1'b1;
   assign min_seg_in = csr_valid ? csr_min_ready_segments : min_seg_ff;

   // ---- pipeline control --------------------------------------------------
   // Stage 0 (accept): issue the row read. Stage 1: merge, write back and
   // load the output register. The output register decouples rsp stalls.
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, commit;

   assign commit    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || commit;
   assign accept    = req_valid && req_ready;

   assign s1_valid_in  = accept ? 1'b1 : (commit ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // ---- stage 0: row address ----------------------------------------------
   logic [RW-1:0] rd_row;

   // reads use the index; 2B uses seg/2, 2A uses seg
   always_comb begin
      if (req_command == rgta_pkg::CMD_READ) begin
         rd_row = req_text_index[5:2];
      end else if (req_block_b[11]) begin
         rd_row = {1'b0, req_block_b[3:1]};
      end else begin
         rd_row = req_block_b[3:0];
      end
   end

   // ---- stage 1 payload ---------------------------------------------------
   logic [1:0]    s1_command_ff;
   logic          s1_group_valid_ff;
   logic [15:0]   s1_block_b_ff;
   logic [15:0]   s1_block_c_ff;
   logic [15:0]   s1_block_d_ff;
   logic [6:0]    s1_index_ff;
   logic [RW-1:0] s1_row_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_command_ff     <= req_command;
         s1_group_valid_ff <= req_group_valid;
         s1_block_b_ff     <= req_block_b;
         s1_block_c_ff     <= req_block_c;
         s1_block_d_ff     <= req_block_d;
         s1_index_ff       <= req_text_index;
         s1_row_ff         <= rd_row;
      end
   end

   // ---- state registers ---------------------------------------------------
   logic [NL-1:0][7:0]  name_ff, name_in;
   logic [15:0]         mask_ff, mask_in;
   logic [1:0]          last_ab_ff, last_ab_in;   // [1] seen, [0] flag
   logic                ready_ff, ready_in;
   logic                eos_ff, eos_in;           // last entry forced NUL
   logic [4:0]          pty_ff, pty_in;
   logic                tp_ff, tp_in;
   logic [rgta_pkg::ROWS-1:0] valid_ff, valid_in; // row holds written data

   // forwarding of a write-back to the row read in the same cycle
   logic              fwd_hit_ff, fwd_hit_in;
   rgta_pkg::row_type fwd_data_ff;

   // ---- text RAM ----------------------------------------------------------
   rgta_pkg::ram_wr_type ram_wr;
   rgta_pkg::row_type    ram_rd_data;

   rgta_text_ram u_text_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (accept),
      .rd_row  (rd_row),
      .rd_data (ram_rd_data)
   );

   // ---- stage 1 decode ----------------------------------------------------
   logic       is_group, is_ps, is_rt, is_clear, is_read;
   logic       ab_flip, wipe;
   logic [3:0] kind;

   assign kind     = s1_block_b_ff[15:12];
   assign is_group = (s1_command_ff == rgta_pkg::CMD_GROUP) && s1_group_valid_ff;
   assign is_ps    = is_group && (kind == rgta_pkg::GROUP_PS);
   assign is_rt    = is_group && (kind == rgta_pkg::GROUP_RT);
   assign is_clear = (s1_command_ff == rgta_pkg::CMD_CLEAR);
   assign is_read  = (s1_command_ff == rgta_pkg::CMD_READ);
   assign ab_flip  = is_rt && last_ab_ff[1] && (last_ab_ff[0] != s1_block_b_ff[4]);
   assign wipe     = ab_flip || is_clear;

   // effective old row: wiped or never-written rows read as reset text
   rgta_pkg::row_type eff_row;

   always_comb begin
      if (wipe || !valid_ff[s1_row_ff]) begin
         eff_row = rgta_pkg::reset_row(s1_row_ff);
      end else if (fwd_hit_ff) begin
         eff_row = fwd_data_ff;
      end else begin
         eff_row = ram_rd_data;
      end
      if (eos_ff && !wipe && s1_row_ff == RW'(rgta_pkg::ROWS - 1)) begin
         eff_row[rgta_pkg::ROW_BYTES-1] = rgta_pkg::CHAR_NUL;
      end
   end

   // ---- row merge ---------------------------------------------------------
   rgta_pkg::merge_req_type merge_req;
   rgta_pkg::row_type       new_row;
   logic                    cr_seen;

   always_comb begin
      merge_req.version_b = s1_block_b_ff[11];
      merge_req.half      = s1_block_b_ff[0];
      if (s1_block_b_ff[11]) begin
         merge_req.chars = {16'h0000, s1_block_d_ff[7:0], s1_block_d_ff[15:8]};
      end else begin
         merge_req.chars = {s1_block_d_ff[7:0], s1_block_d_ff[15:8],
                            s1_block_c_ff[7:0], s1_block_c_ff[15:8]};
      end
   end

   rgta_row_merge u_row_merge (
      .old_row (eff_row),
      .req     (merge_req),
      .new_row (new_row),
      .cr_seen (cr_seen)
   );

   assign ram_wr.en   = commit && is_rt;
   assign ram_wr.row  = s1_row_ff;
   assign ram_wr.data = new_row;

   assign fwd_hit_in = accept ? (ram_wr.en && (s1_row_ff == rd_row)) : fwd_hit_ff;

   // ---- segment readiness -------------------------------------------------
   logic [15:0] mask_rt;
   logic        ready_pre, seg_ready;

   assign mask_rt   = (wipe ? 16'h0000 : mask_ff) | (16'(1) << s1_block_b_ff[3:0]);
   assign ready_pre = (!wipe && ready_ff) || cr_seen;
   assign seg_ready = !ready_pre && (rgta_pkg::popcount16(mask_rt) >= min_seg_ff);

   // ---- next state --------------------------------------------------------
   logic [1:0] ps_addr;

   assign ps_addr = s1_block_b_ff[1:0];

   always_comb begin
      name_in    = name_ff;
      mask_in    = mask_ff;
      last_ab_in = last_ab_ff;
      ready_in   = ready_ff;
      eos_in     = eos_ff;
      pty_in     = pty_ff;
      tp_in      = tp_ff;
      valid_in   = valid_ff;
      if (commit) begin
         if (is_clear) begin
            name_in    = {NL{rgta_pkg::CHAR_SPACE}};
            mask_in    = '0;
            last_ab_in = '0;
            ready_in   = 1'b0;
            eos_in     = 1'b0;
            valid_in   = '0;
         end else if (is_group) begin
            pty_in = s1_block_b_ff[9:5];
            tp_in  = s1_block_b_ff[10];
            if (is_ps) begin
               if (rgta_pkg::printable(s1_block_d_ff[15:8])) begin
                  name_in[{ps_addr, 1'b0}] = s1_block_d_ff[15:8];
               end
               if (rgta_pkg::printable(s1_block_d_ff[7:0])) begin
                  name_in[{ps_addr, 1'b1}] = s1_block_d_ff[7:0];
               end
            end
            if (is_rt) begin
               last_ab_in = {1'b1, s1_block_b_ff[4]};
               if (ab_flip) begin
                  valid_in = '0;
               end
               valid_in[s1_row_ff] = 1'b1;
               mask_in  = mask_rt;
               ready_in = ready_pre || seg_ready;
               // write-back of the last row carries its current last entry
               if (seg_ready) begin
                  eos_in = 1'b1;
               end else if (wipe || s1_row_ff == RW'(rgta_pkg::ROWS - 1)) begin
                  eos_in = 1'b0;
               end
            end
         end
      end
   end

   // ---- read data ---------------------------------------------------------
   logic [7:0] char_val;

   always_comb begin
      if (!is_read) begin
         char_val = rgta_pkg::CHAR_NUL;
      end else if (!s1_index_ff[6]) begin
         char_val = eff_row[s1_index_ff[1:0]];
      end else if (s1_index_ff[5:3] == 3'd0) begin
         char_val = name_ff[s1_index_ff[2:0]];
      end else begin
         char_val = rgta_pkg::CHAR_NUL;
      end
   end

   // ---- registers ---------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         min_seg_ff   <= rgta_pkg::MIN_SEG_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         name_ff      <= {NL{rgta_pkg::CHAR_SPACE}};
         mask_ff      <= '0;
         last_ab_ff   <= '0;
         ready_ff     <= 1'b0;
         eos_ff       <= 1'b0;
         pty_ff       <= '0;
         tp_ff        <= 1'b0;
         valid_ff     <= '0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         min_seg_ff   <= min_seg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         name_ff      <= name_in;
         mask_ff      <= mask_in;
         last_ab_ff   <= last_ab_in;
         ready_ff     <= ready_in;
         eos_ff       <= eos_in;
         pty_ff       <= pty_in;
         tp_ff        <= tp_in;
         valid_ff     <= valid_in;
         fwd_hit_ff   <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_data_ff <= new_row;
      end
   end

   // ---- output register ---------------------------------------------------
   logic        rsp_taken_ff;
   logic [3:0]  rsp_kind_ff;
   logic [4:0]  rsp_pty_ff;
   logic        rsp_tp_ff;
   logic        rsp_ready_flag_ff;
   logic [15:0] rsp_mask_ff;
   logic        rsp_cleared_ff;
   logic [7:0]  rsp_char_ff;

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_taken_ff      <= is_group;
         rsp_kind_ff       <= is_group ? kind : 4'd0;
         rsp_pty_ff        <= pty_in;
         rsp_tp_ff         <= tp_in;
         rsp_ready_flag_ff <= ready_in;
         rsp_mask_ff       <= mask_in;
         rsp_cleared_ff    <= wipe;
         rsp_char_ff       <= char_val;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_group_taken     = rsp_taken_ff;
   assign rsp_group_kind      = rsp_kind_ff;
   assign rsp_program_type    = rsp_pty_ff;
   assign rsp_traffic_program = rsp_tp_ff;
   assign rsp_text_ready      = rsp_ready_flag_ff;
   assign rsp_segments_seen   = rsp_mask_ff;
   assign rsp_text_cleared    = rsp_cleared_ff;
   assign rsp_char_out        = rsp_char_ff;

   // ---- assertions --------------------------------------------------------
`ifndef ASSERT_OFF
   a_eos_needs_ready: assert property (@(posedge clock) disable iff (reset)
      eos_ff |-> ready_ff)
      else $error("last entry forced NUL without text ready");

   a_clear_wipes: assert property (@(posedge clock) disable iff (reset)
      (commit && is_clear) |=> (valid_ff == '0 && mask_ff == '0 && !ready_ff
                                && last_ab_ff == '0 && !eos_ff))
      else $error("clear command left text state behind");

   a_kind_needs_group: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_group_taken) |-> (rsp_group_kind == 4'd0))
      else $error("group kind reported without a processed group");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (valid_ff == '0 && !s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline or row valid bits not cleared by reset");
`endif

endmodule
